// ===== rtl/core/psac_pkg.sv =====
package psac_pkg;

	// Widths of the device control value and of the integral accumulator.
	localparam int PARAM_BITS    = 16;
	localparam int INTEGRAL_BITS = 24;

	// Field and register widths.
	localparam int MEAS_W    = 8;
	localparam int TARGET_W  = 8;
	localparam int BAND_W    = 4;
	localparam int GAIN_W    = 18;
	localparam int WINDUP_W  = 16;
	localparam int FSTEP_W   = 10;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 3;
	localparam int CFG_W     = 18;
	localparam int CFG_IDX_W = 3;

	// Arithmetic widths, derived from the ones above, and the rounding shift.
	localparam int ERR_W      = MEAS_W + 1;
	localparam int DERIV_W    = ERR_W + 1;
	localparam int PROD_P_W   = GAIN_W + 1 + ERR_W;
	localparam int PROD_I_W   = GAIN_W + 1 + INTEGRAL_BITS;
	localparam int PROD_D_W   = GAIN_W + 1 + DERIV_W;
	localparam int SUM_W      = PROD_I_W + 2;
	localparam int ROUND_SH   = 8;
	localparam int MAG_W      = SUM_W + 1 - ROUND_SH;
	localparam int DELTA_W    = MAG_W + 1;
	localparam int MOVE_W     = ((PARAM_BITS > DELTA_W) ? PARAM_BITS : DELTA_W) + 1;
	localparam int CLAMP_W    = INTEGRAL_BITS + 2;

	// Stream widths.
	localparam int IN_FIELDS_W  = MEAS_W + 3 * PARAM_BITS;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = PARAM_BITS + 1 + STATUS_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Constants of the control law.
	localparam logic [MEAS_W-1:0] BEST_SAT_LEVEL = 8'd254;
	localparam int ROUND_HALF = 1 << (ROUND_SH - 1);
	localparam logic [MAG_W-1:0] UNIT_STEP = MAG_W'(1);

	// Mode flag bit positions.
	localparam int MODE_INVERT     = 0;
	localparam int MODE_STOP       = 1;
	localparam int MODE_MIN_TARGET = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET   = 3'd0,
		REG_BAND     = 3'd1,
		REG_GAIN_P   = 3'd2,
		REG_GAIN_I   = 3'd3,
		REG_GAIN_D   = 3'd4,
		REG_WINDUP   = 3'd5,
		REG_FSTEP    = 3'd6,
		REG_MODE     = 3'd7
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_STEPPED   = 3'd0,
		ST_AT_TARGET = 3'd1,
		ST_AT_LIMIT  = 3'd2,
		ST_BEST      = 3'd3,
		ST_BEST_SAT  = 3'd4
	} status_t;

	typedef struct packed {
		logic [TARGET_W-1:0] target_value;
		logic [BAND_W-1:0]   error_band;
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i;
		logic [GAIN_W-1:0]   gain_d;
		logic [WINDUP_W-1:0] windup_limit;
		logic [FSTEP_W-1:0]  fixed_step;
		logic [MODE_W-1:0]   mode_flags;
	} cfg_t;

	// Request as it leaves the front stage.
	typedef struct packed {
		logic signed [ERR_W-1:0]         err;
		logic signed [INTEGRAL_BITS-1:0] integ;
		logic signed [DERIV_W-1:0]       deriv;
		logic signed [PARAM_BITS-1:0]    cur;
		logic signed [PARAM_BITS-1:0]    pmin;
		logic signed [PARAM_BITS-1:0]    pmax;
		logic                            meas_top;
	} front_t;

	// Request with its step magnitude resolved.
	typedef struct packed {
		logic signed [ERR_W-1:0]      err;
		logic [MAG_W-1:0]             mag;
		logic signed [PARAM_BITS-1:0] cur;
		logic signed [PARAM_BITS-1:0] pmin;
		logic signed [PARAM_BITS-1:0] pmax;
		logic                         meas_top;
	} gain_t;

	// Result of one request.
	typedef struct packed {
		status_t                      status;
		logic                         write_param;
		logic signed [PARAM_BITS-1:0] new_param;
	} result_t;

endpackage

// ===== rtl/core/psac_front.sv =====
module psac_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  psac_pkg::cfg_t                      cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [psac_pkg::IN_TDATA_W-1:0]     in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output psac_pkg::front_t                    out_data
);

	localparam int IB = psac_pkg::INTEGRAL_BITS;
	localparam int PB = psac_pkg::PARAM_BITS;
	localparam int MW = psac_pkg::MEAS_W;
	localparam int EW = psac_pkg::ERR_W;
	localparam int CW = psac_pkg::CLAMP_W;

	localparam logic signed [IB-1:0] INT_MAX = {1'b0, {(IB-1){1'b1}}};
	localparam logic signed [IB-1:0] INT_MIN = {1'b1, {(IB-1){1'b0}}};

	logic [MW-1:0]                   meas;
	logic signed [EW-1:0]            err_c;
	logic signed [IB:0]              isum_c;
	logic signed [IB-1:0]            isat_c;
	logic signed [CW-1:0]            iwide_c;
	logic signed [CW-1:0]            lim_c;
	logic signed [CW-1:0]            iclamp_c;
	logic signed [psac_pkg::DERIV_W-1:0] deriv_c;
	logic signed [IB-1:0]            integ_q;
	logic signed [EW-1:0]            prev_q;
	logic                            accept;
	psac_pkg::front_t                data_s1;
	logic                            valid_s1;

	assign meas  = in_data[MW-1:0];
	assign err_c = $signed({1'b0, cfg.target_value}) - $signed({1'b0, meas});

	always_comb begin
		isum_c = {integ_q[IB-1], integ_q} + (IB+1)'(err_c);
		if (isum_c[IB] != isum_c[IB-1]) begin
			isat_c = isum_c[IB] ? INT_MIN : INT_MAX;
		end else begin
			isat_c = isum_c[IB-1:0];
		end
		iwide_c  = CW'(isat_c);
		lim_c    = $signed({{(CW-psac_pkg::WINDUP_W){1'b0}}, cfg.windup_limit});
		iclamp_c = iwide_c;
		if (cfg.windup_limit != '0) begin
			if (iwide_c > lim_c) begin
				iclamp_c = lim_c;
			end else if (iwide_c < -lim_c) begin
				iclamp_c = -lim_c;
			end
		end
	end

	assign deriv_c = {err_c[EW-1], err_c} - {prev_q[EW-1], prev_q};

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	// The integral and previous error only advance on the PID path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
		end else if (accept && cfg.fixed_step == '0) begin
			integ_q <= iclamp_c[IB-1:0];
			prev_q  <= err_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.err      <= err_c;
			data_s1.integ    <= iclamp_c[IB-1:0];
			data_s1.deriv    <= deriv_c;
			data_s1.cur      <= in_data[MW +: PB];
			data_s1.pmin     <= in_data[MW+PB +: PB];
			data_s1.pmax     <= in_data[MW+2*PB +: PB];
			data_s1.meas_top <= meas > psac_pkg::BEST_SAT_LEVEL;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== rtl/core/psac_gain.sv =====
module psac_gain (
	input  logic              clk,
	input  logic              arst_n,
	input  psac_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  psac_pkg::front_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output psac_pkg::gain_t   out_data
);

	localparam int SW = psac_pkg::SUM_W;
	localparam int MG = psac_pkg::MAG_W;

	logic signed [psac_pkg::PROD_P_W-1:0] prod_p_s2;
	logic signed [psac_pkg::PROD_I_W-1:0] prod_i_s2;
	logic signed [psac_pkg::PROD_D_W-1:0] prod_d_s2;
	psac_pkg::front_t                     fr_s2;
	logic                                 valid_s2;
	logic                                 ready_s3;
	psac_pkg::gain_t                      data_s3;
	logic                                 valid_s3;

	logic signed [SW-1:0] sum_c;
	logic [SW-1:0]        abs_c;
	logic [SW:0]          rnd_c;
	logic [MG-1:0]        mag_c;

	assign ready_s3 = !valid_s3 || out_ready;
	assign in_ready = !valid_s2 || ready_s3;

	// Stage 2: the three gain products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_p_s2 <= $signed({1'b0, cfg.gain_p}) * $signed(in_data.err);
			prod_i_s2 <= $signed({1'b0, cfg.gain_i}) * $signed(in_data.integ);
			prod_d_s2 <= $signed({1'b0, cfg.gain_d}) * $signed(in_data.deriv);
			fr_s2     <= in_data;
		end
	end

	// Stage 3: sum, magnitude and rounding half away from zero, or the fixed step when one is set.
	always_comb begin
		sum_c = SW'(prod_p_s2) + SW'(prod_i_s2) + SW'(prod_d_s2);
		abs_c = sum_c[SW-1] ? SW'(-sum_c) : SW'(sum_c);
		rnd_c = {1'b0, abs_c} + (SW+1)'(psac_pkg::ROUND_HALF);
		if (cfg.fixed_step != '0) begin
			mag_c = MG'(cfg.fixed_step);
		end else begin
			mag_c = rnd_c[SW:psac_pkg::ROUND_SH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			data_s3.err      <= fr_s2.err;
			data_s3.mag      <= mag_c;
			data_s3.cur      <= fr_s2.cur;
			data_s3.pmin     <= fr_s2.pmin;
			data_s3.pmax     <= fr_s2.pmax;
			data_s3.meas_top <= fr_s2.meas_top;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

// ===== rtl/core/psac_decide.sv =====
module psac_decide (
	input  logic              clk,
	input  logic              arst_n,
	input  psac_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  psac_pkg::gain_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output psac_pkg::result_t out_data
);

	localparam int EW = psac_pkg::ERR_W;
	localparam int PB = psac_pkg::PARAM_BITS;
	localparam int MG = psac_pkg::MAG_W;
	localparam int DW = psac_pkg::DELTA_W;
	localparam int TW = psac_pkg::MOVE_W;

	logic signed [EW-1:0] last_err_q;
	logic                 moved_up_q;
	logic                 moved_down_q;
	logic                 unit_q;
	psac_pkg::result_t    res_q;
	logic                 valid_q;

	logic                 fire;
	logic [EW-1:0]        err_neg;
	logic [EW-1:0]        last_neg;
	logic [EW-2:0]        err_abs;
	logic [EW-2:0]        last_abs;
	logic                 out_of_band;
	logic                 up;
	logic                 stop;
	logic                 turning;
	logic                 grew;
	logic                 best;
	logic                 go_back;
	logic                 up_eff;
	logic [MG-1:0]        mag_eff;
	logic                 neg;
	logic                 nonzero;
	logic signed [DW-1:0] delta;
	logic signed [TW-1:0] move;
	logic                 at_limit;
	logic                 best_sat;
	logic                 act;
	psac_pkg::result_t    res_c;

	assign err_neg  = -in_data.err;
	assign last_neg = -last_err_q;
	assign err_abs  = in_data.err[EW-1] ? err_neg[EW-2:0] : in_data.err[EW-2:0];
	assign last_abs = last_err_q[EW-1] ? last_neg[EW-2:0] : last_err_q[EW-2:0];

	always_comb begin
		out_of_band = err_abs > (EW-1)'(cfg.error_band);
		up          = !in_data.err[EW-1];
		stop        = cfg.mode_flags[psac_pkg::MODE_STOP] && unit_q;
		turning     = up ? moved_down_q : moved_up_q;
		grew        = err_abs > last_abs;
		best        = stop && turning && !grew;
		go_back     = stop && !turning && grew;
		up_eff      = go_back ? !up : up;
		mag_eff     = (stop && grew) ? psac_pkg::UNIT_STEP : in_data.mag;
		act         = out_of_band && !best;

		neg      = cfg.mode_flags[psac_pkg::MODE_INVERT] ^ !up_eff;
		nonzero  = mag_eff != '0;
		delta    = neg ? -$signed({1'b0, mag_eff}) : $signed({1'b0, mag_eff});
		move     = TW'(in_data.cur) + TW'(delta);
		at_limit = nonzero && ((!neg && in_data.cur == in_data.pmax) ||
			(neg && in_data.cur == in_data.pmin));
		best_sat = cfg.mode_flags[psac_pkg::MODE_MIN_TARGET] && in_data.meas_top &&
			cfg.target_value == psac_pkg::BEST_SAT_LEVEL;

		res_c.new_param   = '0;
		res_c.write_param = 1'b0;
		if (!out_of_band) begin
			res_c.status = psac_pkg::ST_AT_TARGET;
		end else if (best) begin
			res_c.status = best_sat ? psac_pkg::ST_BEST_SAT : psac_pkg::ST_BEST;
		end else if (at_limit) begin
			res_c.status = psac_pkg::ST_AT_LIMIT;
		end else begin
			res_c.status      = psac_pkg::ST_STEPPED;
			res_c.write_param = 1'b1;
			if (move > TW'(in_data.pmax)) begin
				res_c.new_param = in_data.pmax;
			end else if (move < TW'(in_data.pmin)) begin
				res_c.new_param = in_data.pmin;
			end else begin
				res_c.new_param = move[PB-1:0];
			end
		end
	end

	assign in_ready = !valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q   <= '0;
			moved_up_q   <= 1'b0;
			moved_down_q <= 1'b0;
			unit_q       <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
			end
			if (fire && act) begin
				last_err_q   <= in_data.err;
				moved_up_q   <= up_eff;
				moved_down_q <= !up_eff;
				unit_q       <= mag_eff == psac_pkg::UNIT_STEP;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_c;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = res_q;

endmodule

// ===== rtl/core/pid_step_adjust_controller.sv =====
// An accepted request passes through the front, products and magnitude registers in turn and
// then enters the output register, from which the consumer takes it.
// Throughput: one request per cycle while results are taken; the four register stages
// (front, products, magnitude, decision) each take a new request whenever the stage after it moves on.
// Reset: arst_n loads the register bank with its reset values and clears the integral, the
// error history, the direction and unit-step flags and all valid bits; no clearing pass.
module pid_step_adjust_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port.
	input  logic                                 cfg_wr_en,
	input  logic [psac_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psac_pkg::CFG_W-1:0]           cfg_data,
	// Measurement requests.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata from bit 0: measured_value, current_param, param_min, param_max
	input  logic [psac_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// Results.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// tdata from bit 0: new_param, write_param, status, zero padding
	output logic [psac_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	// Register bank. The user must write it only while no request is in flight (the block does
	// not enforce this), so every stage reads it directly without copying it along the pipeline.
	psac_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_value <= 8'd128;
			cfg_q.error_band   <= '0;
			cfg_q.gain_p       <= psac_pkg::GAIN_W'(256);
			cfg_q.gain_i       <= '0;
			cfg_q.gain_d       <= '0;
			cfg_q.windup_limit <= '0;
			cfg_q.fixed_step   <= '0;
			cfg_q.mode_flags   <= '0;
		end else if (cfg_wr_en) begin
			unique case (psac_pkg::cfg_reg_t'(cfg_index))
				psac_pkg::REG_TARGET: cfg_q.target_value <= cfg_data[psac_pkg::TARGET_W-1:0];
				psac_pkg::REG_BAND:   cfg_q.error_band   <= cfg_data[psac_pkg::BAND_W-1:0];
				psac_pkg::REG_GAIN_P: cfg_q.gain_p       <= cfg_data[psac_pkg::GAIN_W-1:0];
				psac_pkg::REG_GAIN_I: cfg_q.gain_i       <= cfg_data[psac_pkg::GAIN_W-1:0];
				psac_pkg::REG_GAIN_D: cfg_q.gain_d       <= cfg_data[psac_pkg::GAIN_W-1:0];
				psac_pkg::REG_WINDUP: cfg_q.windup_limit <= cfg_data[psac_pkg::WINDUP_W-1:0];
				psac_pkg::REG_FSTEP:  cfg_q.fixed_step   <= cfg_data[psac_pkg::FSTEP_W-1:0];
				psac_pkg::REG_MODE:   cfg_q.mode_flags   <= cfg_data[psac_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// The front stage forms the error and, when no fixed step is set, updates the integral and
	// previous error at acceptance, so the accumulator sees requests strictly in arrival order.
	logic              front_valid;
	logic              front_ready;
	psac_pkg::front_t  front_data;

	psac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	// The gain stages register the three products, then the rounded magnitude of their
	// sum, or the fixed step when one is set.
	logic              gain_valid;
	logic              gain_ready;
	psac_pkg::gain_t   gain_data;

	psac_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (gain_valid),
		.out_ready (gain_ready),
		.out_data  (gain_data)
	);

	// The decision stage holds the direction history, which only changes as a request
	// enters the output register, and applies the band, stop mode and device limits.
	psac_pkg::result_t res;

	psac_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (gain_valid),
		.in_ready  (gain_ready),
		.in_data   (gain_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = {{(psac_pkg::OUT_TDATA_W - psac_pkg::OUT_FIELDS_W){1'b0}},
		res.status, res.write_param, res.new_param};

	// A value is issued exactly when the device was stepped.
	a_write_iff_stepped: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.write_param == (res.status == psac_pkg::ST_STEPPED)))
		else $error("write flag and stepped status disagree");

	// A result without a write carries a zero value.
	a_idle_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !res.write_param) |-> (res.new_param == '0))
		else $error("nonzero value on a result without a write");

	// A result held back by the consumer keeps its status and value.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(res)))
		else $error("stalled result changed");

endmodule

// ===== tb/pid_step_checker.sv =====
`timescale 1ns / 100ps
module pid_step_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [psac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [psac_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	// tdata from bit 0: measured_value, current_param, param_min, param_max
	input  logic [psac_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// tdata from bit 0: new_param, write_param, status, zero padding
	input  logic [psac_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output int                                 pending,
	output int                                 mismatches
);
	import psac_pkg::*;

	localparam longint INTEG_HI = (longint'(1) << (INTEGRAL_BITS - 1)) - 1;
	localparam longint INTEG_LO = -INTEG_HI - 1;

	// Register copies, following every write seen on the configuration port.
	logic [TARGET_W-1:0] tgt_level  = 8'd128;
	logic [BAND_W-1:0]   band_width = '0;
	logic [GAIN_W-1:0]   kp         = 18'd256;
	logic [GAIN_W-1:0]   ki         = '0;
	logic [GAIN_W-1:0]   kd         = '0;
	logic [WINDUP_W-1:0] windup     = '0;
	logic [FSTEP_W-1:0]  fixed_step = '0;
	logic [MODE_W-1:0]   mode       = '0;

	// Controller state carried from one request to the next.
	longint integ_acc    = 0;
	longint last_pid_err = 0;
	longint acted_err    = 0;
	bit     went_up      = 1'b0;
	bit     went_down    = 1'b0;
	bit     unit_step    = 1'b0;

	result_t expected_results[$];

	initial begin
		pending    = 0;
		mismatches = 0;
	end

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Works out the result of one request and advances the controller state.
	function automatic result_t predict_step(input logic [IN_TDATA_W-1:0] req);
		longint meas, cur, lo, hi, err, band, mag, sum, delta, nxt;
		bit up, act, turning, grew, sat;
		result_t r;
		meas = longint'(req[MEAS_W-1:0]);
		cur  = longint'($signed(req[MEAS_W +: PARAM_BITS]));
		lo   = longint'($signed(req[MEAS_W + PARAM_BITS +: PARAM_BITS]));
		hi   = longint'($signed(req[MEAS_W + 2 * PARAM_BITS +: PARAM_BITS]));
		err  = longint'(tgt_level) - meas;
		band = longint'(band_width);
		sat  = mode[MODE_MIN_TARGET] && meas > longint'(BEST_SAT_LEVEL)
			&& tgt_level == BEST_SAT_LEVEL;
		r.new_param   = '0;
		r.write_param = 1'b0;
		r.status      = ST_AT_TARGET;

		// The PID state moves on every request while no fixed step is set, inside the band as well.
		if (fixed_step == '0) begin
			integ_acc += err;
			if (integ_acc > INTEG_HI)
				integ_acc = INTEG_HI;
			else if (integ_acc < INTEG_LO)
				integ_acc = INTEG_LO;
			if (windup != '0) begin
				if (integ_acc > longint'(windup))
					integ_acc = longint'(windup);
				else if (integ_acc < -longint'(windup))
					integ_acc = -longint'(windup);
			end
			sum = longint'(kp) * err + longint'(ki) * integ_acc
				+ longint'(kd) * (err - last_pid_err);
			last_pid_err = err;
			if (sum < 0)
				sum = -sum;
			mag = (sum + ROUND_HALF) >>> ROUND_SH;
		end else begin
			mag = longint'(fixed_step);
		end

		if (err < -band || err > band) begin
			up  = (err > band);
			act = 1'b1;
			if (mode[MODE_STOP] && unit_step) begin
				turning = up ? went_down : went_up;
				grew = (err < 0 ? -err : err) > (acted_err < 0 ? -acted_err : acted_err);
				if (turning && !grew) begin
					act      = 1'b0;
					r.status = sat ? ST_BEST_SAT : ST_BEST;
				end else if (turning) begin
					mag = 1;
				end else if (grew) begin
					// Overshot while still moving the same way: one unit back.
					up  = !up;
					mag = 1;
				end
			end
			if (act) begin
				acted_err = err;
				went_up   = up;
				went_down = !up;
				unit_step = (mag == 1);
				delta = mode[MODE_INVERT] ? -mag : mag;
				if (!up)
					delta = -delta;
				if ((cur == hi && delta > 0) || (cur == lo && delta < 0)) begin
					r.status = ST_AT_LIMIT;
				end else begin
					nxt = cur + delta;
					if (nxt > hi)
						nxt = hi;
					else if (nxt < lo)
						nxt = lo;
					r.new_param   = nxt[PARAM_BITS-1:0];
					r.write_param = 1'b1;
					r.status      = ST_STEPPED;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		logic signed [PARAM_BITS-1:0] got_param;
		logic got_write;
		logic [STATUS_W-1:0] got_status;
		if (!arst_n) begin
			tgt_level    = 8'd128;
			band_width   = '0;
			kp           = 18'd256;
			ki           = '0;
			kd           = '0;
			windup       = '0;
			fixed_step   = '0;
			mode         = '0;
			integ_acc    = 0;
			last_pid_err = 0;
			acted_err    = 0;
			went_up      = 1'b0;
			went_down    = 1'b0;
			unit_step    = 1'b0;
			expected_results.delete();
			pending = 0;
		end else begin
			// Results first: one taken at this edge cannot belong to a request
			// accepted at the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				got_param  = m_axis_tdata[PARAM_BITS-1:0];
				got_write  = m_axis_tdata[PARAM_BITS];
				got_status = m_axis_tdata[PARAM_BITS+1 +: STATUS_W];
				if (expected_results.size() == 0) begin
					report($sformatf("result with no request outstanding, tdata %h",
						m_axis_tdata));
				end else begin
					want = expected_results.pop_front();
					if (got_param !== want.new_param)
						report($sformatf("new_param %0d, predicted %0d",
							got_param, want.new_param));
					if (got_write !== want.write_param)
						report($sformatf("write_param %b, predicted %b",
							got_write, want.write_param));
					if (got_status !== want.status)
						report($sformatf("status %0d, predicted %0d",
							got_status, want.status));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(predict_step(s_axis_tdata));
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_TARGET: tgt_level  = cfg_data[TARGET_W-1:0];
					REG_BAND:   band_width = cfg_data[BAND_W-1:0];
					REG_GAIN_P: kp         = cfg_data[GAIN_W-1:0];
					REG_GAIN_I: ki         = cfg_data[GAIN_W-1:0];
					REG_GAIN_D: kd         = cfg_data[GAIN_W-1:0];
					REG_WINDUP: windup     = cfg_data[WINDUP_W-1:0];
					REG_FSTEP:  fixed_step = cfg_data[FSTEP_W-1:0];
					REG_MODE:   mode       = cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== tb/pid_step_adjust_controller_tb.sv =====
`timescale 1ns / 100ps
module pid_step_adjust_controller_tb;
	import psac_pkg::*;

	localparam int HALF_NS       = 2;
	localparam int RESET_CYCLES  = 5;
	// Cycles the result side refuses everything so that the pipeline backs up.
	localparam int HOLD_CYCLES   = 200;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 225;
	// Settling time after the last drain, as a margin.
	localparam int SETTLE_CYCLES = 8;
	// Far beyond the slowest correct run.
	localparam int TIMEOUT_NS    = 2_000_000;

	localparam int PARAM_LO   = -32768;
	localparam int PARAM_HI   = 32767;
	localparam int GAIN_MAX   = 256000;
	localparam int WINDUP_MAX = 50000;
	localparam int FSTEP_MAX  = 1000;
	localparam int BAND_MAX   = 10;
	localparam int MEAS_MAX   = 255;

	localparam int INV_FLAG  = 1 << MODE_INVERT;
	localparam int STOP_FLAG = 1 << MODE_STOP;
	localparam int MINT_FLAG = 1 << MODE_MIN_TARGET;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int pending;
	int mismatches;

	// Idling percentages for the current phase, and a one-shot request for the
	// long hold-off on the result side.
	int gap_pct   = 0;
	int stall_pct = 0;
	bit hold_request = 1'b0;

	// What the stimulus knows of the current settings, used to aim the
	// measurements around the target.
	int cfg_target = 128;
	int cfg_band   = 0;

	pid_step_adjust_controller DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	pid_step_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.pending       (pending),
		.mismatches    (mismatches)
	);

	always begin
		#(HALF_NS) clk = 1'b1;
		#(HALF_NS) clk = 1'b0;
	end

	// Hard stop in case the block hangs or loses results.
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

	// Result side. Every falling edge gets at most one assignment of tready, so
	// the long hold-off and the random stalls never collide within a time step.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Write one register. The enable is left high so that back-to-back writes
	// do not lower and raise it within the same step; the caller lowers it.
	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(negedge clk);
	endtask

	// Rewrite the whole register set. Only called while nothing is in flight.
	task automatic configure(input int tgt, input int band, input int kp, input int ki,
			input int kd, input int wl, input int fs, input int mode);
		cfg_target = tgt;
		cfg_band   = band;
		write_reg(REG_TARGET, tgt);
		write_reg(REG_BAND, band);
		write_reg(REG_GAIN_P, kp);
		write_reg(REG_GAIN_I, ki);
		write_reg(REG_GAIN_D, kd);
		write_reg(REG_WINDUP, wl);
		write_reg(REG_FSTEP, fs);
		write_reg(REG_MODE, mode);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one request, with random gaps in front of it, and return at the
	// falling edge after it was taken. tvalid stays high for a following request.
	task automatic send_request(input int meas, input int cur, input int lo, input int hi);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {PARAM_BITS'(hi), PARAM_BITS'(lo), PARAM_BITS'(cur), MEAS_W'(meas)};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Stop offering and wait until every outstanding result has come back.
	// Always lets at least one edge pass, so tvalid is written once per step.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	function automatic int pick_gain();
		case ($urandom_range(9))
			0:       return 0;
			1:       return GAIN_MAX;
			2, 3, 4: return 256;
			5, 6:    return $urandom_range(600);
			7:       return $urandom_range(GAIN_MAX);
			default: return $urandom_range(64);
		endcase
	endfunction

	// Random request. Most measurements sit just around the error band, so that
	// unit steps, reversals and the stop-mode decisions come up often; limits
	// are mostly narrow windows so that clamping and the at-limit case appear.
	task automatic send_random_request();
		int w, meas, cur, lo, hi;
		w = cfg_band + 3;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: meas = cfg_target + int'($urandom_range(2 * w)) - w;
			6:                meas = $urandom_range(1) ? 0 : MEAS_MAX;
			default:          meas = $urandom_range(MEAS_MAX);
		endcase
		if (meas < 0)
			meas = 0;
		else if (meas > MEAS_MAX)
			meas = MEAS_MAX;

		lo = int'($urandom_range(65535)) + PARAM_LO;
		hi = lo + int'($urandom_range(60));
		if (hi > PARAM_HI)
			hi = PARAM_HI;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: cur = lo + int'($urandom_range(hi - lo));
			5:             cur = $urandom_range(1) ? lo : hi;
			6: begin
				// Swapped limits: minimum above maximum.
				hi = lo - 60 + int'($urandom_range(59));
				if (hi < PARAM_LO)
					hi = PARAM_LO;
				cur = hi + int'($urandom_range(lo - hi));
			end
			7: begin
				lo = PARAM_LO;
				hi = PARAM_HI;
				case ($urandom_range(2))
					0:       cur = PARAM_LO;
					1:       cur = PARAM_HI;
					default: cur = int'($urandom_range(65535)) + PARAM_LO;
				endcase
			end
			default: begin
				hi  = int'($urandom_range(65535)) + PARAM_LO;
				cur = int'($urandom_range(65535)) + PARAM_LO;
			end
		endcase
		send_request(meas, cur, lo, hi);
	endtask

	task automatic random_settings(input int phase);
		int tgt, fs, wl;
		case ($urandom_range(4))
			0:       tgt = 0;
			1:       tgt = MEAS_MAX;
			2:       tgt = BEST_SAT_LEVEL;
			3:       tgt = 128;
			default: tgt = $urandom_range(MEAS_MAX);
		endcase
		case ($urandom_range(4))
			0, 1:    fs = 0;
			2:       fs = 1;
			3:       fs = FSTEP_MAX;
			default: fs = $urandom_range(2, 20);
		endcase
		case ($urandom_range(3))
			0, 1:    wl = 0;
			2:       wl = WINDUP_MAX;
			default: wl = $urandom_range(500);
		endcase
		// The mode follows the phase number, so every combination of flags is run.
		configure(tgt, $urandom_range(BAND_MAX), pick_gain(), pick_gain(), pick_gain(),
			wl, fs, phase % 8);
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_TARGET;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with the settings the block comes out of reset with:
		// at target, full-range moves, both limits, clamping and swapped limits.
		send_request(128, 0, -100, 100);
		send_request(0, 0, PARAM_LO, PARAM_HI);
		send_request(MEAS_MAX, PARAM_HI, PARAM_LO, PARAM_HI);
		send_request(0, PARAM_HI, PARAM_LO, PARAM_HI);
		send_request(MEAS_MAX, PARAM_LO, PARAM_LO, PARAM_HI);
		send_request(0, 32700, 0, PARAM_HI);
		send_request(MEAS_MAX, -32700, PARAM_LO, 0);
		send_request(0, 0, 100, -100);
		drain();

		// Widest band, largest fixed step, inverted control: inside the band,
		// on its edge, just outside it, and a full-scale error.
		configure(MEAS_MAX, BAND_MAX, 256, 0, 0, 0, FSTEP_MAX, INV_FLAG);
		send_request(250, 0, -5000, 5000);
		send_request(245, 0, -5000, 5000);
		send_request(244, 0, -5000, 5000);
		send_request(0, 0, -5000, 5000);
		drain();

		configure(0, 0, 256, 0, 0, 0, FSTEP_MAX, 0);
		send_request(MEAS_MAX, 0, PARAM_LO, PARAM_HI);
		drain();

		// Stop mode with unit steps: best value reached on a reversal, a plain
		// step, stepping back after an overshoot (both ways), and a reversal
		// where the error grew.
		configure(128, 0, 256, 0, 0, 0, 1, STOP_FLAG);
		send_request(127, 0, -50, 50);
		send_request(129, 1, -50, 50);
		send_request(127, 1, -50, 50);
		send_request(120, 2, -50, 50);
		send_request(140, 1, -50, 50);
		send_request(150, 2, -50, 50);
		drain();

		// Best value reached with the measurement saturated.
		configure(BEST_SAT_LEVEL, 0, 256, 0, 0, 0, 1, STOP_FLAG | MINT_FLAG);
		send_request(253, 0, -50, 50);
		send_request(MEAS_MAX, 1, -50, 50);
		drain();

		// Largest gains and windup limit: huge steps that always clamp.
		configure(BEST_SAT_LEVEL, 0, GAIN_MAX, GAIN_MAX, GAIN_MAX, WINDUP_MAX, 0, 0);
		send_request(0, 0, PARAM_LO, PARAM_HI);
		send_request(0, PARAM_LO, PARAM_LO, PARAM_HI);
		send_request(0, -1000, PARAM_LO, PARAM_HI);
		send_request(MEAS_MAX, 0, PARAM_LO, PARAM_HI);
		drain();

		// Random part. Phases rotate through no idling, sender idle, receiver
		// stalling and both; every phase starts from a fresh random setting.
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 64; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 64; end
				default: begin gap_pct = 36; stall_pct = 36; end
			endcase
			random_settings(p);
			// With the sender never idle, a long hold on the result side fills
			// the pipeline and makes the block refuse requests.
			if (p % 4 == 0)
				hold_request = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_random_request();
				// Half way through, the sender waits for every result to come back.
				if (p % 4 == 1 && i == PHASE_ITEMS / 2)
					drain();
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
